// ===== src/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the small language tokenizer
// Transaction types, token kind codes, scan modes and keyword tables used by
// the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package slt_pkg;

  // Word length counter width; covers the largest supported buffer (63).
  localparam int WLEN_W   = 6;
  localparam int KW_COUNT = 8;

  // Token kinds
  localparam logic [4:0] KIND_IF     = 5'd0;
  localparam logic [4:0] KIND_IDENT  = 5'd8;
  localparam logic [4:0] KIND_LIT    = 5'd9;
  localparam logic [4:0] KIND_ASSIGN = 5'd10;
  localparam logic [4:0] KIND_PLUS   = 5'd11;
  localparam logic [4:0] KIND_MINUS  = 5'd12;
  localparam logic [4:0] KIND_STAR   = 5'd13;
  localparam logic [4:0] KIND_SLASH  = 5'd14;
  localparam logic [4:0] KIND_AMP    = 5'd15;
  localparam logic [4:0] KIND_EQ     = 5'd16;
  localparam logic [4:0] KIND_LT     = 5'd17;
  localparam logic [4:0] KIND_GT     = 5'd18;
  localparam logic [4:0] KIND_LE     = 5'd19;
  localparam logic [4:0] KIND_GE     = 5'd20;
  localparam logic [4:0] KIND_LPAREN = 5'd21;
  localparam logic [4:0] KIND_RPAREN = 5'd22;
  localparam logic [4:0] KIND_LBRACE = 5'd23;
  localparam logic [4:0] KIND_RBRACE = 5'd24;
  localparam logic [4:0] KIND_LBRACK = 5'd25;
  localparam logic [4:0] KIND_RBRACK = 5'd26;
  localparam logic [4:0] KIND_SEMI   = 5'd27;
  localparam logic [4:0] KIND_COMMA  = 5'd28;
  localparam logic [4:0] KIND_END    = 5'd29;
  // Returned by the operator lookup for a byte that is no operator; the
  // code is shared with the first keyword but never emitted from there.
  localparam logic [4:0] KIND_NONE   = KIND_IF;

  localparam logic [7:0] CH_EQ = "=";
  localparam logic [7:0] CH_LT = "<";
  localparam logic [7:0] CH_GT = ">";
  localparam logic [7:0] CH_US = "_";

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_LIT  = 3'b010,
    MODE_WORD = 3'b100
  } mode_t;

  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_EQ   = 2'd1,
    HELD_LT   = 2'd2,
    HELD_GT   = 2'd3
  } held_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] text_char;
    logic       token_end;
    logic       truncated;
    logic       run_last;
  } out_t;

  // One command from the front end to the back end: either a single token
  // or a run of buffered text characters.
  typedef struct packed {
    logic              text;
    logic [4:0]        kind;
    logic [WLEN_W-1:0] len;
    logic              bank;
    logic              trunc;
    logic              last;
  } cmd_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [4:0] single_op_kind(logic [7:0] c);
    logic [4:0] k;
    case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "&":     k = KIND_AMP;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "[":     k = KIND_LBRACK;
      "]":     k = KIND_RBRACK;
      ";":     k = KIND_SEMI;
      ",":     k = KIND_COMMA;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] held_single(held_t h);
    logic [4:0] k;
    case (h)
      HELD_LT: k = KIND_LT;
      HELD_GT: k = KIND_GT;
      default: k = KIND_ASSIGN;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] held_pair(held_t h);
    logic [4:0] k;
    case (h)
      HELD_LT: k = KIND_LE;
      HELD_GT: k = KIND_GE;
      default: k = KIND_EQ;
    endcase
    return k;
  endfunction

  function automatic logic [WLEN_W-1:0] kw_len(logic [2:0] k);
    logic [WLEN_W-1:0] n;
    case (k)
      3'd0:    n = WLEN_W'(2);
      3'd1:    n = WLEN_W'(4);
      3'd2:    n = WLEN_W'(4);
      3'd3:    n = WLEN_W'(5);
      3'd4:    n = WLEN_W'(3);
      3'd5:    n = WLEN_W'(4);
      3'd6:    n = WLEN_W'(4);
      default: n = WLEN_W'(6);
    endcase
    return n;
  endfunction

  // Keyword text, left aligned and padded with blanks to six characters.
  function automatic logic [7:0] kw_char(logic [2:0] k, logic [2:0] pos);
    logic [47:0] s;
    logic [7:0]  c;
    case (k)
      3'd0:    s = "if    ";
      3'd1:    s = "else  ";
      3'd2:    s = "goto  ";
      3'd3:    s = "label ";
      3'd4:    s = "int   ";
      3'd5:    s = "void  ";
      3'd6:    s = "func  ";
      default: s = "return";
    endcase
    case (pos)
      3'd0:    c = s[47:40];
      3'd1:    c = s[39:32];
      3'd2:    c = s[31:24];
      3'd3:    c = s[23:16];
      3'd4:    c = s[15:8];
      3'd5:    c = s[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/slt_ram.sv =====
// ----------------------------------------------------------------------------
// slt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module slt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/slt_cmdq.sv =====
// ----------------------------------------------------------------------------
// slt_cmdq: command queue between tokenizer front end and back end
// Small register FIFO of token commands.
// ----------------------------------------------------------------------------
module slt_cmdq #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_push,
  input  slt_pkg::cmd_t q_push_cmd,
  output logic          q_full,
  input  logic          q_pop,
  output slt_pkg::cmd_t q_cmd,
  output logic          q_empty
);
  import slt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_cmd   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (q_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (q_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (q_push && !q_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!q_push && q_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wptr_r] <= q_push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_full |-> q_pop)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command queue read while empty");

endmodule

// ===== src/slt_front.sv =====
// ----------------------------------------------------------------------------
// slt_front: tokenizer front end
// Accepts source bytes, tracks scan mode and held operator, writes word
// characters to the buffer RAM, and queues token commands for the back end.
// ----------------------------------------------------------------------------
module slt_front #(
  parameter int MAX_WORD = 32,
  parameter int IW       = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  slt_pkg::in_t  in_item,
  output logic          q_push,
  output slt_pkg::cmd_t q_push_cmd,
  input  logic          q_full,
  input  logic          text_done,
  output logic          wr_en,
  output logic [IW:0]   wr_addr,
  output logic [7:0]    wr_data
);
  import slt_pkg::*;

  mode_t             mode_r, mode_nxt;
  held_t             held_r, held_nxt;
  logic [WLEN_W-1:0] len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic              bank_r, bank_nxt;
  logic              busy_r, busy_nxt;
  logic [2:0]        slot_v_r, slot_v_nxt;
  logic [KW_COUNT-1:0] match_r, match_nxt;
  cmd_t              slot_r [3];

  logic              accept, mode_lit, mode_word, mode_act;
  logic              dig, alp, wch;
  logic              kw_hit, flush_kw;
  logic [2:0]        kw_idx;
  cmd_t              a_cmd, b_cmd, c_cmd;
  logic              a_v, b_v, c_v;
  logic              do_append, start_word, text_create;
  logic [WLEN_W-1:0] len_base;
  logic [KW_COUNT-1:0] match_base;
  logic              ovf_base;
  logic [1:0]        sel;

  assign mode_lit  = (mode_r == MODE_LIT);
  assign mode_word = (mode_r == MODE_WORD);
  assign mode_act  = mode_lit || mode_word;
  // A byte may flush the current word and start the next one; the other bank
  // must be free then.
  assign in_full   = (|slot_v_r) || (mode_act && busy_r);
  assign accept    = in_push && !in_full;

  assign dig = is_digit(in_item.ch);
  assign alp = is_alpha(in_item.ch);
  assign wch = dig || alp || (in_item.ch == CH_US);

  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (match_r[k] && (len_r == kw_len(3'(k)))) begin
        kw_hit = 1'b1;
        kw_idx = 3'(k);
      end
    end
  end

  assign flush_kw = mode_word && !ovf_r && kw_hit;

  always_comb begin
    mode_nxt   = mode_r;
    held_nxt   = held_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    bank_nxt   = bank_r;
    match_nxt  = match_r;
    a_v        = 1'b0;
    b_v        = 1'b0;
    c_v        = 1'b0;
    do_append  = 1'b0;
    start_word = 1'b0;
    wr_en      = 1'b0;

    a_cmd       = '0;
    a_cmd.kind  = held_single(held_r);
    b_cmd       = '0;
    b_cmd.text  = !flush_kw;
    b_cmd.kind  = flush_kw ? {2'b00, kw_idx} : (mode_lit ? KIND_LIT : KIND_IDENT);
    b_cmd.len   = len_r;
    b_cmd.bank  = bank_r;
    b_cmd.trunc = ovf_r;
    c_cmd       = '0;
    c_cmd.kind  = KIND_END;

    if (accept) begin
      if (in_item.end_of_text) begin
        a_v      = (held_r != HELD_NONE);
        b_v      = mode_act;
        c_v      = 1'b1;
        held_nxt = HELD_NONE;
        mode_nxt = MODE_IDLE;
      end else if ((held_r != HELD_NONE) && (in_item.ch == CH_EQ)) begin
        a_v        = 1'b1;
        a_cmd.kind = held_pair(held_r);
        held_nxt   = HELD_NONE;
      end else begin
        a_v      = (held_r != HELD_NONE);
        held_nxt = HELD_NONE;
        if ((mode_lit && dig) || (mode_word && wch)) begin
          do_append = 1'b1;
        end else begin
          b_v      = mode_act;
          mode_nxt = MODE_IDLE;
          if (dig || alp) begin
            start_word = 1'b1;
            do_append  = 1'b1;
            mode_nxt   = dig ? MODE_LIT : MODE_WORD;
          end else if (in_item.ch == CH_EQ) begin
            held_nxt = HELD_EQ;
          end else if (in_item.ch == CH_LT) begin
            held_nxt = HELD_LT;
          end else if (in_item.ch == CH_GT) begin
            held_nxt = HELD_GT;
          end else begin
            c_cmd.kind = single_op_kind(in_item.ch);
            c_v        = (c_cmd.kind != KIND_NONE);
          end
        end
      end
    end

    a_cmd.last = !b_v && !c_v;
    b_cmd.last = !c_v;
    c_cmd.last = 1'b1;

    // Text flush hands the current bank to the back end; swap banks.
    text_create = b_v && !flush_kw;
    if (text_create) begin
      bank_nxt = ~bank_r;
    end
    busy_nxt = text_create ? 1'b1 : (text_done ? 1'b0 : busy_r);

    len_base   = start_word ? '0 : len_r;
    match_base = start_word ? '1 : match_r;
    ovf_base   = start_word ? 1'b0 : ovf_r;
    if (do_append) begin
      if (len_base < WLEN_W'(MAX_WORD)) begin
        wr_en   = 1'b1;
        len_nxt = len_base + WLEN_W'(1);
        ovf_nxt = ovf_base;
        for (int k = 0; k < KW_COUNT; k++) begin
          match_nxt[k] = match_base[k] && (len_base < kw_len(3'(k))) &&
                         (kw_char(3'(k), len_base[2:0]) == in_item.ch);
        end
      end else begin
        len_nxt   = len_base;
        ovf_nxt   = 1'b1;
        match_nxt = match_base;
      end
    end

    slot_v_nxt = slot_v_r;
    if (accept) begin
      slot_v_nxt = {c_v, b_v, a_v};
    end else if (q_push) begin
      slot_v_nxt[sel] = 1'b0;
    end
  end

  assign wr_addr = {bank_nxt, len_base[IW-1:0]};
  assign wr_data = in_item.ch;

  // Drain pending commands in token order, one per cycle while the queue is not full.
  always_comb begin
    if (slot_v_r[0]) begin
      sel = 2'd0;
    end else if (slot_v_r[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  assign q_push     = (|slot_v_r) && !q_full;
  assign q_push_cmd = slot_r[sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      held_r   <= HELD_NONE;
      len_r    <= '0;
      ovf_r    <= 1'b0;
      bank_r   <= 1'b0;
      busy_r   <= 1'b0;
      slot_v_r <= '0;
    end else begin
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
      bank_r   <= bank_nxt;
      busy_r   <= busy_nxt;
      slot_v_r <= slot_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
    if (accept) begin
      slot_r[0] <= a_cmd;
      slot_r[1] <= b_cmd;
      slot_r[2] <= c_cmd;
    end
  end

  a_one_text_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    text_create |-> !busy_r)
    else $error("second text run queued while buffer bank busy");

  a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    text_done |-> busy_r)
    else $error("text run finished with no run outstanding");

endmodule

// ===== src/slt_back.sv =====
// ----------------------------------------------------------------------------
// slt_back: tokenizer back end
// Pops token commands, reads buffered word text and drives the result
// register; it sends all text of one command before it pops the next.
// ----------------------------------------------------------------------------
module slt_back #(
  parameter int IW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  slt_pkg::cmd_t q_cmd,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          rd_en,
  output logic [IW:0]   rd_addr,
  input  logic [7:0]    rd_data,
  output logic          text_done,
  output logic          out_empty,
  input  logic          out_pop,
  output slt_pkg::out_t out_item
);
  import slt_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_TEXT = 2'b10
  } bstate_t;

  bstate_t           state_r, state_nxt;
  cmd_t              cur_r, cur_nxt;
  logic [WLEN_W-1:0] idx_r, idx_nxt;
  out_t              obuf_r, obuf_nxt;
  logic              obuf_v_r, obuf_v_nxt;
  logic              load_ok, load, last_ch;
  logic [WLEN_W-1:0] idx_inc;

  assign load_ok   = !obuf_v_r || out_pop;
  assign idx_inc   = idx_r + WLEN_W'(1);
  assign last_ch   = (idx_inc == cur_r.len);
  assign out_empty = !obuf_v_r;
  assign out_item  = obuf_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    obuf_nxt  = obuf_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = {q_cmd.bank, {IW{1'b0}}};
    load      = 1'b0;
    text_done = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.text) begin
            q_pop     = 1'b1;
            rd_en     = 1'b1;
            cur_nxt   = q_cmd;
            idx_nxt   = '0;
            state_nxt = B_TEXT;
          end else if (load_ok) begin
            q_pop              = 1'b1;
            load               = 1'b1;
            obuf_nxt.kind      = q_cmd.kind;
            obuf_nxt.text_char = 8'h00;
            obuf_nxt.token_end = 1'b1;
            obuf_nxt.truncated = 1'b0;
            obuf_nxt.run_last  = q_cmd.last;
          end
        end
      end
      B_TEXT: begin
        rd_addr = {cur_r.bank, idx_inc[IW-1:0]};
        if (load_ok) begin
          load               = 1'b1;
          obuf_nxt.kind      = cur_r.kind;
          obuf_nxt.text_char = rd_data;
          obuf_nxt.token_end = last_ch;
          obuf_nxt.truncated = cur_r.trunc;
          obuf_nxt.run_last  = cur_r.last && last_ch;
          if (last_ch) begin
            text_done = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            rd_en   = 1'b1;
            idx_nxt = idx_inc;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    obuf_v_nxt = load ? 1'b1 : (out_pop ? 1'b0 : obuf_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      obuf_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      obuf_v_r <= obuf_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    obuf_r <= obuf_nxt;
  end

  a_text_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_TEXT) |-> (cur_r.len != '0) && (idx_r < cur_r.len))
    else $error("text run index out of range");

endmodule

// ===== src/small_language_tokenizer.sv =====
// ----------------------------------------------------------------------------
// small_language_tokenizer: streaming tokenizer for a small C-like language
// Source bytes in, tokens out; word and literal text leaves one character
// per result transaction.
// ----------------------------------------------------------------------------
//
//   channel  | handshake         | payload   | transaction
//   ---------+-------------------+-----------+-------------------------------
//   input    | push / full       | in_item   | push && !full at clk edge
//   result   | pop / empty       | out_item  | pop && !empty at clk edge
//
// Input: a byte that only extends a word or literal, or yields nothing,
//   queues no command; a byte that yields tokens holds full while its
//   commands (held operator, flushed word, operator or end) go one at a
//   time through the front end's single queue write port.
// Text: the back end streams word text from the buffer RAM at one character
//   per cycle unless the result register is held; full holds while a new
//   word is in progress and the previous word text has not yet drained.
// Reset: rst_n is synchronous, active low; no clearing pass (word buffer is
//   written before it is read).
// Stalls: the result register and command queue let the input side keep
//   going while a finished result waits for pop.
//
module small_language_tokenizer #(
  parameter int MAX_WORD   = 32,
  parameter int CMDQ_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  slt_pkg::in_t  in_item,
  output logic          empty,
  input  logic          pop,
  output slt_pkg::out_t out_item
);
  import slt_pkg::*;

  // Word index width; the buffer holds two banks of 2**IW characters so the
  // front end can fill one word while the back end drains the previous one.
  localparam int IW = $clog2(MAX_WORD);
  localparam int AW = IW + 1;

  logic          q_push, q_full, q_pop, q_empty;
  cmd_t          q_push_cmd, q_cmd;
  logic          text_done;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Front end: classify bytes, hold scan state, queue token commands.
  slt_front #(
    .MAX_WORD (MAX_WORD),
    .IW       (IW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (push),
    .in_full    (full),
    .in_item    (in_item),
    .q_push     (q_push),
    .q_push_cmd (q_push_cmd),
    .q_full     (q_full),
    .text_done  (text_done),
    .wr_en      (ram_we),
    .wr_addr    (ram_waddr),
    .wr_data    (ram_wdata)
  );

  // Decouple the two halves so each can stall on its own.
  slt_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_push     (q_push),
    .q_push_cmd (q_push_cmd),
    .q_full     (q_full),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd),
    .q_empty    (q_empty)
  );

  // Word buffer, two banks selected by the top address bit.
  slt_ram #(
    .WIDTH (8),
    .DEPTH (2 ** AW)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Back end: expand commands into result transactions.
  slt_back #(
    .IW (IW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (q_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .rd_en     (ram_re),
    .rd_addr   (ram_raddr),
    .rd_data   (ram_rdata),
    .text_done (text_done),
    .out_empty (empty),
    .out_pop   (pop),
    .out_item  (out_item)
  );

  // Front end must never write the bank the back end is draining.
  a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re |-> ram_waddr[AW-1] != ram_raddr[AW-1])
    else $error("word buffer bank written while being read");

endmodule

// ===== dv/small_language_tokenizer_test.sv =====
// ----------------------------------------------------------------------------
// small_language_tokenizer_test: self-checking bench for the tokenizer
// Feeds source bytes through the push/full queue port, predicts the token
// stream per accepted byte and checks every popped result field by field.
// ----------------------------------------------------------------------------

class token_checker #(int WORD_MAX = 32);

  slt_pkg::out_t expected_tokens[$];
  int            errors;
  string         keywords[8];

  protected slt_pkg::mode_t mode;
  protected slt_pkg::held_t held;
  protected logic [7:0]     word_buf[WORD_MAX];
  protected int             word_len;
  protected bit             word_ovf;
  protected logic [4:0]     op_kind[logic [7:0]];

  function new();
    mode     = slt_pkg::MODE_IDLE;
    held     = slt_pkg::HELD_NONE;
    word_len = 0;
    word_ovf = 1'b0;
    errors   = 0;
    keywords = '{"if", "else", "goto", "label", "int", "void", "func", "return"};
    op_kind["+"] = slt_pkg::KIND_PLUS;
    op_kind["-"] = slt_pkg::KIND_MINUS;
    op_kind["*"] = slt_pkg::KIND_STAR;
    op_kind["/"] = slt_pkg::KIND_SLASH;
    op_kind["&"] = slt_pkg::KIND_AMP;
    op_kind["("] = slt_pkg::KIND_LPAREN;
    op_kind[")"] = slt_pkg::KIND_RPAREN;
    op_kind["{"] = slt_pkg::KIND_LBRACE;
    op_kind["}"] = slt_pkg::KIND_RBRACE;
    op_kind["["] = slt_pkg::KIND_LBRACK;
    op_kind["]"] = slt_pkg::KIND_RBRACK;
    op_kind[";"] = slt_pkg::KIND_SEMI;
    op_kind[","] = slt_pkg::KIND_COMMA;
  endfunction

  protected function bit is_num(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  protected function bit is_letter(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  protected function void emit(logic [4:0] kind, logic [7:0] c, bit fin, bit trunc);
    slt_pkg::out_t t;
    t.kind      = kind;
    t.text_char = c;
    t.token_end = fin;
    t.truncated = trunc;
    t.run_last  = 1'b0;
    expected_tokens = {expected_tokens, t};
  endfunction

  protected function void add_char(logic [7:0] c);
    if (word_len < WORD_MAX) begin
      word_buf[word_len] = c;
      word_len++;
    end else begin
      word_ovf = 1'b1;
    end
  endfunction

  // Close the pending word or literal: keyword match first, else its text.
  protected function void close_text();
    logic [4:0] kind;
    bit         hit;
    for (int k = 0; k < 8; k++) begin
      if (mode == slt_pkg::MODE_WORD && !word_ovf && keywords[k].len() == word_len) begin
        hit = 1'b1;
        for (int i = 0; i < word_len; i++)
          if (8'(keywords[k][i]) != word_buf[i]) hit = 1'b0;
        if (hit) begin
          emit(slt_pkg::KIND_IF + 5'(k), 8'h00, 1'b1, 1'b0);
          mode     = slt_pkg::MODE_IDLE;
          word_len = 0;
          return;
        end
      end
    end
    kind = (mode == slt_pkg::MODE_LIT) ? slt_pkg::KIND_LIT : slt_pkg::KIND_IDENT;
    for (int i = 0; i < word_len; i++)
      emit(kind, word_buf[i], i + 1 == word_len, word_ovf);
    mode     = slt_pkg::MODE_IDLE;
    word_len = 0;
    word_ovf = 1'b0;
  endfunction

  protected function void close_held(bit with_eq);
    logic [4:0] kind;
    case (held)
      slt_pkg::HELD_EQ: kind = with_eq ? slt_pkg::KIND_EQ : slt_pkg::KIND_ASSIGN;
      slt_pkg::HELD_LT: kind = with_eq ? slt_pkg::KIND_LE : slt_pkg::KIND_LT;
      slt_pkg::HELD_GT: kind = with_eq ? slt_pkg::KIND_GE : slt_pkg::KIND_GT;
      default:          kind = slt_pkg::KIND_END;
    endcase
    if (held != slt_pkg::HELD_NONE) emit(kind, 8'h00, 1'b1, 1'b0);
    held = slt_pkg::HELD_NONE;
  endfunction

  protected function void scan_char(logic [7:0] c);
    if (held != slt_pkg::HELD_NONE) begin
      if (c == slt_pkg::CH_EQ) begin
        close_held(1'b1);
        return;
      end
      close_held(1'b0);
    end
    if (mode == slt_pkg::MODE_LIT) begin
      if (is_num(c)) begin
        add_char(c);
        return;
      end
      close_text();
    end else if (mode == slt_pkg::MODE_WORD) begin
      if (is_num(c) || is_letter(c) || c == slt_pkg::CH_US) begin
        add_char(c);
        return;
      end
      close_text();
    end
    if (is_num(c) || is_letter(c)) begin
      mode     = is_num(c) ? slt_pkg::MODE_LIT : slt_pkg::MODE_WORD;
      word_len = 0;
      word_ovf = 1'b0;
      add_char(c);
    end else if (c == slt_pkg::CH_EQ) begin
      held = slt_pkg::HELD_EQ;
    end else if (c == slt_pkg::CH_LT) begin
      held = slt_pkg::HELD_LT;
    end else if (c == slt_pkg::CH_GT) begin
      held = slt_pkg::HELD_GT;
    end else if (op_kind.exists(c)) begin
      emit(op_kind[c], 8'h00, 1'b1, 1'b0);
    end
  endfunction

  function void note_byte(slt_pkg::in_t item);
    int            mark;
    int            tail;
    slt_pkg::out_t t;
    mark = expected_tokens.size();
    if (item.end_of_text) begin
      close_held(1'b0);
      if (mode != slt_pkg::MODE_IDLE) close_text();
      emit(slt_pkg::KIND_END, 8'h00, 1'b1, 1'b0);
    end else begin
      scan_char(item.ch);
    end
    if (expected_tokens.size() > mark) begin
      tail = expected_tokens.size() - 1;
      t = expected_tokens[tail];
      t.run_last = 1'b1;
      expected_tokens[tail] = t;
    end
  endfunction

  protected function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function void check_token(slt_pkg::out_t got);
    slt_pkg::out_t want;
    if (expected_tokens.size() == 0) begin
      flag($sformatf("unexpected token: kind %0d char %02h end %b trunc %b last %b",
                     got.kind, got.text_char, got.token_end, got.truncated, got.run_last));
      return;
    end
    want = expected_tokens.pop_front();
    if (got.kind !== want.kind || got.text_char !== want.text_char ||
        got.token_end !== want.token_end || got.truncated !== want.truncated ||
        got.run_last !== want.run_last)
      flag($sformatf({"token mismatch: expected kind %0d char %02h end %b trunc %b",
                      " last %b, got kind %0d char %02h end %b trunc %b last %b"},
                     want.kind, want.text_char, want.token_end, want.truncated,
                     want.run_last, got.kind, got.text_char, got.token_end,
                     got.truncated, got.run_last));
  endfunction

endclass

module small_language_tokenizer_test;
  import slt_pkg::*;

  localparam int WORD_MAX     = 32;
  localparam int TARGET_ITEMS = 480;
  localparam int CALM_ITEMS   = 80;    // tail of the run with no idling
  localparam int PHASE_ITEMS  = 60;    // items between changes of idle rate
  localparam int QUIET_LIMIT  = 2000;  // cycles without any transaction
  localparam int DRAIN_CYCLES = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic push  = 1'b0;
  logic pop   = 1'b0;
  in_t  in_item = '0;
  logic full;
  logic empty;
  out_t out_item;

  token_checker #(WORD_MAX) token_sb;

  int sender_gap_pct = 0;
  int reader_gap_pct = 0;
  int reader_stall   = 0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  string pair_ops[6] = '{"==", "<=", ">=", "=", "<", ">"};
  string one_ops     = "+-*/&(){}[];,";

  always #5 clk = ~clk;

  small_language_tokenizer #(
    .MAX_WORD(WORD_MAX)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  // Result side: drive pop at the falling edge, stalling in random bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (reader_stall > 0) begin
      pop <= 1'b0;
      reader_stall--;
    end else if ($urandom_range(0, 99) < reader_gap_pct) begin
      pop <= 1'b0;
      reader_stall = $urandom_range(1, 17) - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // Check each popped result against the oldest predicted token.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) token_sb.check_token(out_item);
  end

  // Watchdog: end the run if neither side moves a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // Hold push low for a random burst before the next byte, at the sender's rate.
  task automatic sender_gap();
    int n;
    if ($urandom_range(0, 99) < sender_gap_pct) begin
      n = $urandom_range(1, 17);
      @(negedge clk) push <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Offer one byte, hold it until the transaction completes, then predict it.
  task automatic send_item(bit eot, logic [7:0] c);
    in_t item;
    item.ch          = c;
    item.end_of_text = eot;
    sender_gap();
    @(negedge clk);
    push    <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (full);
    token_sb.note_byte(item);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic send_eot();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Drop push and hold off until every predicted token has been popped.
  task automatic drain_results();
    @(negedge clk) push <= 1'b0;
    while (token_sb.expected_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return "a" + 8'(r);
    if (r < 52) return "A" + 8'(r - 26);
    if (r < 62) return "0" + 8'(r - 52);
    return CH_US;
  endfunction

  function automatic int text_len();
    // Mostly short text; now and then straddle the buffer size.
    if ($urandom_range(0, 9) == 0) return $urandom_range(WORD_MAX - 2, WORD_MAX + 8);
    return $urandom_range(1, 8);
  endfunction

  task automatic send_word();
    int    r;
    int    len;
    string kw;
    r  = $urandom_range(0, 99);
    kw = token_sb.keywords[$urandom_range(0, 7)];
    if (r < 40) begin
      send_text(kw);
    end else if (r < 50) begin
      // keyword with a tail: must come out as an identifier
      send_text(kw);
      send_item(1'b0, word_char());
    end else begin
      len = text_len();
      send_item(1'b0, ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25)));
      repeat (len - 1) send_item(1'b0, word_char());
    end
    if ($urandom_range(0, 1)) send_item(1'b0, " ");
  endtask

  task automatic send_literal();
    int len;
    len = text_len();
    repeat (len) send_item(1'b0, "0" + 8'($urandom_range(0, 9)));
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0:       send_item(1'b0, 8'($urandom_range(0, 255)));
      1:       send_item(1'b0, 8'($urandom_range(128, 255)));
      default: send_item(1'b0, 8'($urandom_range(0, 31)));
    endcase
  endtask

  // One random piece of source text: mostly well-formed tokens, some noise,
  // and now and then a broken tail such as a held operator cut by the end.
  task automatic send_random_piece();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      send_word();
    end else if (r < 40) begin
      send_literal();
    end else if (r < 55) begin
      send_item(1'b0, one_ops[$urandom_range(0, one_ops.len() - 1)]);
    end else if (r < 67) begin
      send_text(pair_ops[$urandom_range(0, 5)]);
    end else if (r < 77) begin
      send_item(1'b0, " ");
    end else if (r < 87) begin
      send_noise();
    end else if (r < 92) begin
      send_eot();
    end else begin
      send_text(pair_ops[$urandom_range(3, 5)]);
      send_eot();
    end
  endtask

  function automatic int pick_gap_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 25;
      default: return 60;
    endcase
  endfunction

  initial begin
    int  phase;
    bit  paused;
    token_sb = new();

    // Hold reset, then release it at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: keyword, extreme bytes, literal running into a word, every
    // operator in one_ops, the pairs >= and ==, a held < flushed by the end,
    // a keyword flushed by the end, and a second end on an idle scanner.
    sender_gap_pct = 20;
    reader_gap_pct = 20;
    send_text("if");
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_text("12a>=(x_9){}[],+-*/&;==<");
    send_eot();
    send_text("else");
    send_eot();
    send_eot();
    drain_results();

    // Random: change idle rates per phase, pause once for a full drain,
    // and finish with a stretch that has no idling at all.
    phase  = -1;
    paused = 1'b0;
    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= TARGET_ITEMS - CALM_ITEMS) begin
        sender_gap_pct = 0;
        reader_gap_pct = 0;
      end else if (items_sent / PHASE_ITEMS != phase) begin
        phase          = items_sent / PHASE_ITEMS;
        sender_gap_pct = pick_gap_pct();
        reader_gap_pct = pick_gap_pct();
      end
      if (!paused && items_sent >= TARGET_ITEMS / 2) begin
        paused = 1'b1;
        drain_results();
      end
      send_random_piece();
    end
    send_eot();

    // Wait for the last tokens, then watch for strays.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (token_sb.errors == 0 && token_sb.expected_tokens.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
